@@ hw/rtl/ctp_pkg.sv @@
// Package for the text CAN frame parser: character codes, status codes,
// parser phase encoding, result record and the hex digit decoder.
// No dependencies.
package ctp_pkg;

    localparam int MaxDataBytesDefault = 8;

    localparam logic [7:0] ChHash = 8'h23;
    localparam logic [7:0] ChDot  = 8'h2E;
    localparam logic [7:0] ChRUp  = 8'h52;
    localparam logic [7:0] ChRLo  = 8'h72;

    localparam logic [4:0] HexMax     = 5'h0F;
    localparam logic [4:0] RemoteMax  = 5'd8;
    localparam logic [3:0] IdStdDigits = 4'd3;
    localparam logic [3:0] IdExtDigits = 4'd8;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_FD  = 2'd2;
    localparam logic [1:0] ST_RSV = 2'd3;

    localparam int IdWidth   = 29;
    localparam int DataWidth = 64;

    typedef enum logic [6:0] {
        PH_ID     = 7'b0000001,
        PH_AFTER  = 7'b0000010,
        PH_HIGH   = 7'b0000100,
        PH_LOW    = 7'b0001000,
        PH_RDLC   = 7'b0010000,
        PH_FDFLAG = 7'b0100000,
        PH_IGNORE = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [DataWidth-1:0] payload;
        logic [3:0]           length_code;
        logic                 remote;
        logic                 extended;
        logic [IdWidth-1:0]   identifier;
        logic [1:0]           status;
    } t_result;

    // Value 0..15 of a hex digit, 16 for any other character.
    function automatic logic [4:0] ctp_hex(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/can_frame_text_parser.sv @@
// Text CAN frame parser, top level: input register, parser core and result
// register. Depends on ctp_pkg and ctp_core.
// Throughput: one character per cycle; only a final character waits, and only
// while the result register holds a result that has not been taken.
// o_m_tvalid rises when the result of the final character is written into the result register.
// Reset: synchronous, active low; empties both registers and clears the parser.
module can_frame_text_parser
    import ctp_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MaxDataBytesDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // character[7:0]
    input  logic         i_s_tlast,   // last
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata    // status[1:0], identifier[30:2], extended[31],
                                      // remote[32], length_code[36:33],
                                      // payload[100:37], zero[103:101]
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       res_valid;
    t_result    res;

    // A final character may only go through the parser when the result
    // register is free or being emptied in this cycle.
    assign advance    = r_in_valid && !(r_in_last && r_out_valid && !i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    ctp_core #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_char     (r_in_char),
        .i_last     (r_in_last),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out};

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.status != ST_RSV)
        else $error("reserved status code on the result");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |->
        (r_out.identifier == '0 && !r_out.extended && !r_out.remote
         && r_out.length_code == 4'd0 && r_out.payload == '0))
        else $error("failed frame carries nonzero fields");

    a_remote_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.remote) |->
        (r_out.payload == '0 && r_out.length_code <= 4'd8))
        else $error("remote frame result malformed");

    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.length_code <= 4'(MAX_DATA_BYTES) || r_out.remote)
        else $error("length code beyond data byte limit");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_char)
                                      && $stable(r_in_last)))
        else $error("stalled character lost from the input register");

endmodule

@@ hw/rtl/ctp_core.sv @@
// Parser state registers and the per-character next-state logic; produces
// the frame result on the marked final character. Depends on ctp_pkg.
module ctp_core
    import ctp_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MaxDataBytesDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int PayW = 8 * MAX_DATA_BYTES;

    t_phase               r_phase, n_phase;
    logic [IdWidth-1:0]   r_id, n_id;
    logic [3:0]           r_id_cnt, n_id_cnt;
    logic [PayW-1:0]      r_pay, n_pay;
    logic [3:0]           r_byte_cnt, n_byte_cnt;
    logic [3:0]           r_high, n_high;
    logic                 r_dot, n_dot;
    logic                 r_remote, n_remote;
    logic [3:0]           r_rlen, n_rlen;
    logic [1:0]           r_err, n_err;

    logic [4:0] v;
    logic       v_hex;
    logic [1:0] status;

    assign v     = ctp_hex(i_char);
    assign v_hex = (v <= HexMax);

    always_comb begin
        n_phase    = r_phase;
        n_id       = r_id;
        n_id_cnt   = r_id_cnt;
        n_pay      = r_pay;
        n_byte_cnt = r_byte_cnt;
        n_high     = r_high;
        n_dot      = r_dot;
        n_remote   = r_remote;
        n_rlen     = r_rlen;
        n_err      = r_err;
        case (r_phase)
            PH_ID: begin
                if ((r_id_cnt == IdStdDigits || r_id_cnt == IdExtDigits)
                        && i_char == ChHash) begin
                    n_phase = PH_AFTER;
                end else if (r_id_cnt < IdExtDigits && v_hex) begin
                    n_id     = {r_id[IdWidth-5:0], v[3:0]};
                    n_id_cnt = r_id_cnt + 4'd1;
                end else begin
                    n_err   = ST_BAD;
                    n_phase = PH_IGNORE;
                end
            end
            PH_AFTER, PH_HIGH: begin
                if (r_phase == PH_AFTER && (i_char == ChRUp || i_char == ChRLo)) begin
                    n_remote = 1'b1;
                    n_phase  = PH_RDLC;
                end else if (r_phase == PH_AFTER && i_char == ChHash) begin
                    n_phase = PH_FDFLAG;
                end else if (i_char == ChDot && !r_dot) begin
                    n_dot   = 1'b1;
                    n_phase = PH_HIGH;
                end else if (v_hex) begin
                    n_high  = v[3:0];
                    n_phase = PH_LOW;
                end else begin
                    n_err   = ST_BAD;
                    n_phase = PH_IGNORE;
                end
            end
            PH_LOW: begin
                if (v_hex) begin
                    for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                        if (r_byte_cnt == 4'(i)) begin
                            n_pay[8*i +: 8] = {r_high, v[3:0]};
                        end
                    end
                    n_byte_cnt = r_byte_cnt + 4'd1;
                    n_dot      = 1'b0;
                    n_phase    = (n_byte_cnt >= 4'(MAX_DATA_BYTES)) ? PH_IGNORE : PH_HIGH;
                end else begin
                    n_err   = ST_BAD;
                    n_phase = PH_IGNORE;
                end
            end
            PH_RDLC: begin
                if (v <= RemoteMax) begin
                    n_rlen = v[3:0];
                end
                n_phase = PH_IGNORE;
            end
            PH_FDFLAG: begin
                n_err   = v_hex ? ST_FD : ST_BAD;
                n_phase = PH_IGNORE;
            end
            default: begin
            end
        endcase
    end

    // A frame that stops inside the identifier, between the digits of a
    // byte, or before the CAN FD flags digit is incomplete.
    always_comb begin
        status = n_err;
        if (status == ST_OK && (n_phase == PH_ID || n_phase == PH_LOW
                                || n_phase == PH_FDFLAG)) begin
            status = ST_BAD;
        end
        o_res = '0;
        o_res.status = status;
        if (status == ST_OK) begin
            o_res.identifier = n_id;
            o_res.extended   = (n_id_cnt == IdExtDigits);
            o_res.remote     = n_remote;
            if (n_remote) begin
                o_res.length_code = n_rlen;
            end else begin
                o_res.length_code = n_byte_cnt;
                o_res.payload     = DataWidth'(n_pay);
            end
        end
    end

    assign o_res_valid = i_step && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase    <= PH_ID;
            r_id       <= '0;
            r_id_cnt   <= '0;
            r_pay      <= '0;
            r_byte_cnt <= '0;
            r_high     <= '0;
            r_dot      <= 1'b0;
            r_remote   <= 1'b0;
            r_rlen     <= '0;
            r_err      <= ST_OK;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_id       <= n_id;
            r_id_cnt   <= n_id_cnt;
            r_pay      <= n_pay;
            r_byte_cnt <= n_byte_cnt;
            r_high     <= n_high;
            r_dot      <= n_dot;
            r_remote   <= n_remote;
            r_rlen     <= n_rlen;
            r_err      <= n_err;
        end
    end

endmodule
